// File: rtl/ica_pkg.sv
// Shared types and codes for the integer calculator ALU.
`timescale 1ns / 1ps
package ica_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;
  localparam logic [2:0] OP_SQRT = 3'd6;
  localparam logic [2:0] OP_CBRT = 3'd7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_NEG_ROOT = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]         opcode;
  } ica_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status_code;
  } ica_out_t;

endpackage

// File: rtl/ica_mul.sv
// Iterative shift-add multiplier, one partial product per cycle.
`timescale 1ns / 1ps
module ica_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   x,
  input  logic [W-1:0]   y,
  output logic [2*W-1:0] prod,
  output logic           done
);
  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] prod_r, mcand_r;
  logic [W-1:0]   mplier_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      prod_r   <= '0;
      mcand_r  <= {{W{1'b0}}, x};
      mplier_r <= y;
    end else if (busy_r) begin
      if (mplier_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign prod = prod_r;
  assign done = done_r;
endmodule

// File: rtl/ica_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ica_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, quo_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    shifted, trial;

  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // keep the trial difference only when it did not go negative
      rem_r <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], ~trial[W]};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;
endmodule

// File: rtl/integer_calculator_alu_top.sv
// Top level of the integer calculator ALU: sequencer, shared units, result register.
`timescale 1ns / 1ps
// One transaction in, one transaction out. Add and subtract are computed at dispatch;
// multiply, divide and remainder go through the shared shift-add multiplier or
// restoring divider; square root runs bit by bit in its own state; cube root takes
// two multiplies per result bit; power takes up to exponent multiplies, bounded by
// overflow after at most DATA_WIDTH multiplies. The input is taken only in idle,
// while a finished result may still wait in the output register.
module integer_calculator_alu_top
  import ica_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ica_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ica_out_t out_data
);
  localparam int W  = DATA_WIDTH;
  localparam int CB = (W + 2) / 3;
  localparam int SW = $clog2(CB);
  localparam logic [W-1:0] MINV   = W'(1) << (W - 1);
  localparam logic [W-1:0] MAXP   = ~MINV;
  localparam logic [W-1:0] MASK   = '1;
  localparam logic [W-1:0] SQ_BIT = W'(1) << (2 * ((W - 1) / 2));

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MUL_WAIT, S_DIV_WAIT, S_POW_STEP, S_POW_WAIT,
    S_SQRT, S_CBRT_SQ, S_CBRT_SQ_WAIT, S_CBRT_CU_WAIT, S_FINISH
  } state_t;

  state_t       state_r, state_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [2:0]   op_r, op_nxt;
  logic [W-1:0] res_r, res_nxt, acc_r, acc_nxt, n_r, n_nxt, bit_r, bit_nxt;
  status_t      st_r, st_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         neg_r, neg_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [W-1:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic         mul_start_r, mul_start_nxt, div_start_r, div_start_nxt;
  logic         out_valid_r, out_valid_nxt;
  ica_out_t     out_data_r, out_data_nxt;

  logic [2*W-1:0] prod;
  logic           mul_done, div_done;
  logic [W-1:0]   quo, rem;

  logic         a_neg, b_neg;
  logic [W-1:0] a_mag, b_mag, cand, acc_cb;
  logic [W:0]   sq_sum;

  ica_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r), .x(ux_r), .y(uy_r),
    .prod(prod), .done(mul_done)
  );

  ica_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(ux_r), .divisor(uy_r),
    .quotient(quo), .remainder(rem), .done(div_done)
  );

  assign a_neg  = a_r[W-1];
  assign b_neg  = b_r[W-1];
  assign a_mag  = a_neg ? (W'(0) - a_r) : a_r;
  assign b_mag  = b_neg ? (W'(0) - b_r) : b_r;
  assign cand   = acc_r | (W'(1) << s_r);
  assign sq_sum = {1'b0, acc_r} + {1'b0, bit_r};
  assign acc_cb = (prod <= {{W{1'b0}}, n_r}) ? bit_r : acc_r;

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    op_nxt        = op_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    s_nxt         = s_r;
    ux_nxt        = ux_r;
    uy_nxt        = uy_r;
    mul_start_nxt = 1'b0;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt     = W'(in_data.operand_a);
          b_nxt     = W'(in_data.operand_b);
          op_nxt    = in_data.opcode;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_nxt    = ST_OK;
        res_nxt   = '0;
        state_nxt = S_FINISH;
        unique case (op_r) inside
          OP_ADD: res_nxt = a_r + b_r;
          OP_SUB: res_nxt = a_r - b_r;
          OP_MUL: begin
            ux_nxt        = a_r;
            uy_nxt        = b_r;
            mul_start_nxt = 1'b1;
            state_nxt     = S_MUL_WAIT;
          end
          OP_DIV, OP_MOD: begin
            if (b_r == '0) begin
              st_nxt = ST_DIV_ZERO;
            end else if (op_r == OP_DIV && a_r == MINV && b_r == MASK) begin
              res_nxt = MAXP;
              st_nxt  = ST_OVERFLOW;
            end else begin
              ux_nxt        = a_mag;
              uy_nxt        = b_mag;
              div_start_nxt = 1'b1;
              state_nxt     = S_DIV_WAIT;
            end
          end
          OP_POW: begin
            neg_nxt = a_neg && b_r[0];
            acc_nxt = W'(1);
            n_nxt   = a_mag;
            cnt_nxt = b_r[6:0];
            if (b_neg) begin
              if (a_r == '0) begin
                res_nxt = MAXP;
                st_nxt  = ST_OVERFLOW;
              end else if (a_r == W'(1)) begin
                res_nxt = W'(1);
              end else if (a_r == MASK) begin
                res_nxt = b_r[0] ? MASK : W'(1);
              end
            end else if (b_r == '0) begin
              res_nxt = W'(1);
            end else if (a_mag <= W'(1)) begin
              res_nxt = (a_neg && b_r[0]) ? MASK : a_mag;
            end else if (b_r > W'(64)) begin
              res_nxt = (a_neg && b_r[0]) ? MINV : MAXP;
              st_nxt  = ST_OVERFLOW;
            end else begin
              state_nxt = S_POW_STEP;
            end
          end
          OP_SQRT: begin
            if (a_neg) begin
              st_nxt = ST_NEG_ROOT;
            end else begin
              n_nxt     = a_r;
              acc_nxt   = '0;
              bit_nxt   = SQ_BIT;
              state_nxt = S_SQRT;
            end
          end
          OP_CBRT: begin
            neg_nxt   = a_neg;
            n_nxt     = a_mag;
            acc_nxt   = '0;
            s_nxt     = SW'(CB - 1);
            state_nxt = S_CBRT_SQ;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          res_nxt   = prod[W-1:0];
          state_nxt = S_FINISH;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (op_r == OP_DIV) res_nxt = (a_neg != b_neg) ? (W'(0) - quo) : quo;
          else                res_nxt = a_neg ? (W'(0) - rem) : rem;
          state_nxt = S_FINISH;
        end
      end
      S_POW_STEP: begin
        if (cnt_r == '0) begin
          res_nxt   = neg_r ? (W'(0) - acc_r) : acc_r;
          state_nxt = S_FINISH;
        end else begin
          ux_nxt        = acc_r;
          uy_nxt        = n_r;
          mul_start_nxt = 1'b1;
          state_nxt     = S_POW_WAIT;
        end
      end
      S_POW_WAIT: begin
        if (mul_done) begin
          // product beyond the signed limit means the power has overflowed
          if (prod > {{W{1'b0}}, (neg_r ? MINV : MAXP)}) begin
            res_nxt   = neg_r ? MINV : MAXP;
            st_nxt    = ST_OVERFLOW;
            state_nxt = S_FINISH;
          end else begin
            acc_nxt   = prod[W-1:0];
            cnt_nxt   = cnt_r - 7'd1;
            state_nxt = S_POW_STEP;
          end
        end
      end
      S_SQRT: begin
        if ({1'b0, n_r} >= sq_sum) begin
          n_nxt   = n_r - sq_sum[W-1:0];
          acc_nxt = (acc_r >> 1) + bit_r;
        end else begin
          acc_nxt = acc_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[W-1:2] == '0) begin
          res_nxt   = acc_nxt;
          state_nxt = S_FINISH;
        end
      end
      S_CBRT_SQ: begin
        bit_nxt       = cand;
        ux_nxt        = cand;
        uy_nxt        = cand;
        mul_start_nxt = 1'b1;
        state_nxt     = S_CBRT_SQ_WAIT;
      end
      S_CBRT_SQ_WAIT: begin
        if (mul_done) begin
          ux_nxt        = prod[W-1:0];
          uy_nxt        = bit_r;
          mul_start_nxt = 1'b1;
          state_nxt     = S_CBRT_CU_WAIT;
        end
      end
      S_CBRT_CU_WAIT: begin
        if (mul_done) begin
          acc_nxt = acc_cb;
          if (s_r == '0) begin
            res_nxt   = neg_r ? (W'(0) - acc_cb) : acc_cb;
            state_nxt = S_FINISH;
          end else begin
            s_nxt     = s_r - SW'(1);
            state_nxt = S_CBRT_SQ;
          end
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.result_value = 32'(signed'(res_r));
          out_data_nxt.status_code  = st_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    op_r       <= op_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
    acc_r      <= acc_nxt;
    n_r        <= n_nxt;
    bit_r      <= bit_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    s_r        <= s_nxt;
    ux_r       <= ux_nxt;
    uy_r       <= uy_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISPATCH)
    else $error("accepted transaction not dispatched");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL_WAIT || state_r == S_POW_WAIT ||
                  state_r == S_CBRT_SQ_WAIT || state_r == S_CBRT_CU_WAIT))
    else $error("multiplier finished outside a wait state");
`endif
endmodule

// File: tb/sv/integer_calculator_alu_top_tb.sv
// Self-checking testbench for the integer calculator ALU: directed table, then random traffic.
`timescale 1ns / 1ps
module integer_calculator_alu_top_tb;
  import ica_pkg::*;

  localparam int NUM_RANDOM = 1300;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic signed [31:0] MAXP = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  typedef struct {
    ica_in_t  stim;
    logic     known;
    ica_out_t want;
  } vec_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ica_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ica_out_t out_data;

  ica_out_t result_queue[$];
  int       errors;
  int       sent;
  int       received;
  int       idle_cycles;
  bit       quiet_phase;
  bit       sending_done;
  bit       hold_off_req;
  int       op_hits[8];

  integer_calculator_alu_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Floor square root, bit by bit.
  function automatic logic [31:0] floor_sqrt(input logic [31:0] n);
    logic [31:0] r;
    logic [31:0] t;
    r = 0;
    for (int s = 15; s >= 0; s--) begin
      t = r | (32'd1 << s);
      if (64'(t) * 64'(t) <= 64'(n)) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] floor_cbrt(input logic [31:0] n);
    logic [31:0] r;
    logic [31:0] t;
    r = 0;
    for (int s = 10; s >= 0; s--) begin
      t = r | (32'd1 << s);
      if (64'(t) * 64'(t) * 64'(t) <= 64'(n)) r = t;
    end
    return r;
  endfunction

  function automatic ica_out_t alu_predict(input ica_in_t x);
    ica_out_t    y;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    logic [63:0] acc;
    logic [63:0] lim;
    bit          neg_res;
    bit          ovf;
    a = x.operand_a;
    b = x.operand_b;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    y.result_value = 0;
    y.status_code = ST_OK;
    case (x.opcode)
      OP_ADD: y.result_value = a + b;
      OP_SUB: y.result_value = a - b;
      OP_MUL: y.result_value = a * b;
      OP_DIV: begin
        if (b == 0) y.status_code = ST_DIV_ZERO;
        else if (a == MINV && b == 32'hffffffff) begin
          y.result_value = MAXP;
          y.status_code = ST_OVERFLOW;
        end else begin
          q = ma / mb;
          y.result_value = (a[31] != b[31]) ? -q : q;
        end
      end
      OP_MOD: begin
        if (b == 0) y.status_code = ST_DIV_ZERO;
        else begin
          q = ma % mb;
          y.result_value = a[31] ? -q : q;
        end
      end
      OP_POW: begin
        neg_res = a[31] && b[0];
        if (b[31]) begin
          if (a == 0) begin
            y.result_value = MAXP;
            y.status_code = ST_OVERFLOW;
          end else if (a == 1) y.result_value = 1;
          else if (a == 32'hffffffff) y.result_value = b[0] ? -1 : 1;
          else y.result_value = 0;
        end else if (b == 0) y.result_value = 1;
        else if (ma <= 1) y.result_value = neg_res ? -1 : ma;
        else begin
          lim = neg_res ? 64'h80000000 : 64'h7fffffff;
          acc = 1;
          ovf = b > 64;
          for (int i = 0; i < 64 && !ovf && i < int'(b); i++) begin
            if (acc > lim / ma) ovf = 1;
            else acc = acc * ma;
          end
          if (ovf) begin
            y.result_value = neg_res ? MINV : MAXP;
            y.status_code = ST_OVERFLOW;
          end else y.result_value = neg_res ? -acc[31:0] : acc[31:0];
        end
      end
      OP_SQRT: begin
        if (a[31]) y.status_code = ST_NEG_ROOT;
        else y.result_value = floor_sqrt(a);
      end
      default: begin
        q = floor_cbrt(ma);
        y.result_value = a[31] ? -q : q;
      end
    endcase
    return y;
  endfunction

  function automatic vec_t mk(input logic [31:0] a, input logic [31:0] b,
                              input logic [2:0] op, input bit known = 0,
                              input logic [31:0] r = 0, input status_t st = ST_OK);
    vec_t v;
    v.stim.operand_a = a;
    v.stim.operand_b = b;
    v.stim.opcode = op;
    v.known = known;
    v.want.result_value = r;
    v.want.status_code = st;
    return v;
  endfunction

  // Bias operands toward edges and small values so powers and roots stay interesting.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12);
      1: return -$urandom_range(0, 12);
      2: return {$urandom_range(0, 1) ? MINV : MAXP} ^ $urandom_range(0, 1);
      3: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; leaves valid high for a following transaction.
  task automatic send_one(input ica_in_t x);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_data <= x;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_queue.push_back(alu_predict(x));
    op_hits[x.opcode]++;
    sent++;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    vec_t   dir[$];
    ica_in_t x;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    sent = 0;
    quiet_phase = 0;
    sending_done = 0;
    hold_off_req = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    dir.push_back(mk(MAXP, 1, OP_ADD, 1, MINV));
    dir.push_back(mk(MINV, 1, OP_SUB, 1, MAXP));
    dir.push_back(mk(MINV, -1, OP_MUL, 1, MINV));
    dir.push_back(mk(7, 0, OP_DIV, 1, 0, ST_DIV_ZERO));
    dir.push_back(mk(7, 0, OP_MOD, 1, 0, ST_DIV_ZERO));
    dir.push_back(mk(MINV, -1, OP_DIV, 1, MAXP, ST_OVERFLOW));
    dir.push_back(mk(MINV, -1, OP_MOD, 1, 0));
    dir.push_back(mk(-7, 2, OP_DIV));
    dir.push_back(mk(-7, 2, OP_MOD));
    dir.push_back(mk(2, 31, OP_POW, 1, MAXP, ST_OVERFLOW));
    dir.push_back(mk(-2, 31, OP_POW, 1, MINV));
    dir.push_back(mk(-2, 33, OP_POW, 1, MINV, ST_OVERFLOW));
    dir.push_back(mk(0, 0, OP_POW, 1, 1));
    dir.push_back(mk(1, -5, OP_POW, 1, 1));
    dir.push_back(mk(-1, -5, OP_POW, 1, -1));
    dir.push_back(mk(-1, -4, OP_POW, 1, 1));
    dir.push_back(mk(5, -1, OP_POW, 1, 0));
    dir.push_back(mk(0, MINV, OP_POW, 1, MAXP, ST_OVERFLOW));
    dir.push_back(mk(3, MAXP, OP_POW, 1, MAXP, ST_OVERFLOW));
    dir.push_back(mk(-3, 0, OP_SQRT, 1, 0, ST_NEG_ROOT));
    dir.push_back(mk(MAXP, MINV, OP_SQRT, 1, 46340));
    dir.push_back(mk(MINV, MAXP, OP_CBRT, 1, -1290));
    dir.push_back(mk(-27, 0, OP_CBRT, 1, -3));
    dir.push_back(mk(MAXP, 0, OP_CBRT, 1, 1290));

    foreach (dir[i]) begin
      if (dir[i].known && alu_predict(dir[i].stim) != dir[i].want) begin
        $display("%0t predictor disagrees on row %0d: expected %0d/%0d got %0d/%0d",
                 $realtime, i, dir[i].want.result_value, dir[i].want.status_code,
                 alu_predict(dir[i].stim).result_value,
                 alu_predict(dir[i].stim).status_code);
        errors++;
      end
      send_one(dir[i].stim);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) hold_off_req = 1;
      if (n == NUM_RANDOM - 150) quiet_phase = 1;
      x.operand_a = rand_operand();
      x.operand_b = rand_operand();
      x.opcode = $urandom_range(0, 7);
      if (x.opcode == OP_POW && $urandom_range(0, 1)) x.operand_b = $urandom_range(0, 34);
      send_one(x);
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  // Result side: random stall bursts, plus one long hold-off.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Check results and keep the watchdog
  initial begin
    ica_out_t w;
    received = 0;
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      idle_cycles++;
      if (in_valid && in_ready) idle_cycles = 0;
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        received++;
        if (result_queue.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %0d/%0d",
                   $realtime, out_data.result_value, out_data.status_code);
          errors++;
        end else begin
          w = result_queue.pop_front();
          if (out_data.result_value !== w.result_value) begin
            $display("%0t result_value mismatch: expected %0d actual %0d",
                     $realtime, w.result_value, out_data.result_value);
            errors++;
          end
          if (out_data.status_code !== w.status_code) begin
            $display("%0t status_code mismatch: expected %0d actual %0d",
                     $realtime, w.status_code, out_data.status_code);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
      if (sending_done && result_queue.size() == 0) begin
        repeat (200) begin
          @(posedge clk);
          if (out_valid && out_ready) begin
            $display("%0t unexpected result: expected none, actual %0d/%0d",
                     $realtime, out_data.result_value, out_data.status_code);
            errors++;
          end
        end
        $display("Sent %0d operations, %0d results checked", sent, received);
        $display("Per opcode add..cbrt: %0d %0d %0d %0d %0d %0d %0d %0d",
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3],
                 op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
        if (errors == 0) begin
          $display("Test completed successfully");
        end else begin
          $display("Test completed with failures");
        end
        $finish;
      end
    end
  end

endmodule

// File: integer_calculator_alu_top.f
rtl/ica_pkg.sv
rtl/ica_mul.sv
rtl/ica_div.sv
rtl/integer_calculator_alu_top.sv
tb/sv/integer_calculator_alu_top_tb.sv
